// ===== sv/jest_pkg.sv =====
// Shared types and constants for the joystick event state tracker.
`default_nettype none
package jest_pkg;

  // Event command codes
  localparam logic [2:0] CMD_AXIS     = 3'd0;
  localparam logic [2:0] CMD_BTN_DOWN = 3'd1;
  localparam logic [2:0] CMD_BTN_UP   = 3'd2;
  localparam logic [2:0] CMD_HAT      = 3'd3;

  localparam logic [7:0] AXIS_X = 8'd0;
  localparam logic [7:0] AXIS_Y = 8'd1;

  localparam int         NUM_BUTTONS = 32;
  localparam logic [14:0] DZ_RESET   = 15'd3000;

  // Quotient bits produced by the divider, one per step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [2:0]          command;
    logic [7:0]          index;
    logic signed [15:0]  value;
  } jest_in_t;

  typedef struct packed {
    logic signed [15:0]  axis_x;
    logic signed [15:0]  axis_y;
    logic [31:0]         buttons;
    logic [3:0]          hat;
  } jest_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_COMMIT
  } jest_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic eval;
    logic div_step;
    logic fin;
    logic commit;
  } jest_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic changed;
    logic out_free;
  } jest_sts_t;

endpackage
`default_nettype wire

// ===== sv/joystick_event_state_tracker.sv =====
// Top level of the joystick event state tracker: controller plus datapath.
// Flow: an axis 0/1 event that needs the 16-step divider runs EVAL, DIV and FIN before
//   COMMIT; every other event (saturated axes included) goes from EVAL to COMMIT.
// One transaction at a time: a new input waits until the last one leaves COMMIT;
//   the next input is taken the cycle after COMMIT, later if the output is stalled.
// Reset (rst, synchronous): positions, buttons and hat cleared, deadzone 3000.
`default_nettype none
module joystick_event_state_tracker #(
  parameter int NUM_BUTTONS = jest_pkg::NUM_BUTTONS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [14:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jest_pkg::jest_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jest_pkg::jest_out_t      out_data
);
  import jest_pkg::*;

  // command / status between the sequencer and the datapath
  jest_ctl_t ctl;
  jest_sts_t sts;

  // Sequencer: IDLE -> EVAL -> (DIV x16 -> FIN) -> COMMIT.
  // COMMIT waits only when a changed state meets a full, stalled output register.
  jest_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: deadzone compare, saturation check, divider, state and output
  // register. The output register lets a new transaction enter while the last
  // result is still waiting downstream.
  jest_dpath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // One item in flight: an accepted transaction blocks the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // A commit happens only on a real change with room in the output register.
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> sts.changed && sts.out_free)
    else $error("commit without change or without output room");

  // Output valid only rises from a commit.
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.commit))
    else $error("output valid without a commit");

endmodule
`default_nettype wire

// ===== sv/jest_ctrl.sv =====
// Sequencer for event evaluation, axis division and state commit.
`default_nettype none
module jest_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire jest_pkg::jest_sts_t sts,
  output jest_pkg::jest_ctl_t  ctl
);
  import jest_pkg::*;

  jest_state_t          state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    ctl          = '0;
    in_stall     = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval     = 1'b1;
        div_cnt_next = '0;
        state_next   = sts.need_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold a changed transaction until the output register can take it; unchanged ones skip the commit
        if (!sts.changed) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/jest_dpath.sv =====
// Datapath: event registers, deadzone divider, joystick state and output register.
`default_nettype none
module jest_dpath #(
  parameter int NUM_BUTTONS = jest_pkg::NUM_BUTTONS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [14:0]          cfg_data,
  input  wire jest_pkg::jest_in_t   in_data,
  input  wire jest_pkg::jest_ctl_t  ctl,
  output jest_pkg::jest_sts_t       sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output jest_pkg::jest_out_t       out_data
);
  import jest_pkg::*;

  logic [14:0]        deadzone;
  logic [2:0]         cmd_r;
  logic [7:0]         idx_r;
  logic signed [15:0] val_r;

  logic signed [15:0] norm;
  logic [15:0]        rem;
  logic [15:0]        shreg;
  logic [15:0]        quo;
  logic [15:0]        span_r;
  logic               neg_r;

  logic signed [15:0] x_position;
  logic signed [15:0] y_position;
  logic [31:0]        pressed_bits;
  logic [3:0]         hat_code;

  // deadzone arithmetic on the latched value
  logic        neg;
  logic [15:0] mag;
  logic        in_dz;
  logic [15:0] diff;
  logic [15:0] span;
  logic        ovf;
  logic        is_xy;

  always_comb begin
    neg    = val_r[15];
    mag    = neg ? 16'(~val_r + 16'sd1) : 16'(val_r);
    in_dz  = mag < {1'b0, deadzone};
    diff   = mag - {1'b0, deadzone};
    span   = neg ? (16'd32768 - {1'b0, deadzone}) : (16'd32767 - {1'b0, deadzone});
    // quotient would not fit 16 bits: saturates anyway
    ovf    = {1'b0, diff} >= {span, 1'b0};
    is_xy  = (cmd_r == CMD_AXIS) && ((idx_r == AXIS_X) || (idx_r == AXIS_Y));
  end

  // one restoring division step
  logic [16:0] trial;
  logic        take;
  always_comb begin
    trial = {rem, shreg[15]};
    take  = trial >= {1'b0, span_r};
  end

  // change detection
  logic        btn_ok;
  logic [31:0] bit_mask;
  logic [31:0] want;
  logic        changed;
  always_comb begin
    btn_ok   = ({1'b0, idx_r} < 9'(NUM_BUTTONS)) && (idx_r < 8'd32);
    bit_mask = 32'd1 << idx_r[4:0];
    want     = (cmd_r == CMD_BTN_DOWN) ? bit_mask : 32'd0;
    changed  = 1'b0;
    unique case (cmd_r)
      CMD_AXIS: begin
        if (idx_r == AXIS_X) begin
          changed = (norm != x_position);
        end else if (idx_r == AXIS_Y) begin
          changed = (norm != y_position);
        end
      end
      CMD_BTN_DOWN, CMD_BTN_UP: begin
        changed = btn_ok && ((pressed_bits & bit_mask) != want);
      end
      CMD_HAT: begin
        changed = (val_r[3:0] != hat_code);
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  always_comb begin
    sts.need_div = is_xy && !in_dz && !ovf;
    sts.changed  = changed;
    sts.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= DZ_RESET;
    end else if (cfg_write) begin
      deadzone <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= in_data.command;
      idx_r <= in_data.index;
      val_r <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      rem    <= {1'b0, diff[15:1]};
      shreg  <= {diff[0], 15'd0};
      quo    <= '0;
      span_r <= span;
      neg_r  <= neg;
      if (in_dz) begin
        norm <= '0;
      end else begin
        norm <= neg ? 16'sh8000 : 16'sh7FFF;
      end
    end else if (ctl.div_step) begin
      rem   <= take ? 16'(trial - {1'b0, span_r}) : trial[15:0];
      quo   <= {quo[14:0], take};
      shreg <= {shreg[14:0], 1'b0};
    end else if (ctl.fin) begin
      if (neg_r) begin
        norm <= (quo > 16'd32768) ? 16'sh8000 : $signed(16'(16'd0 - quo));
      end else begin
        norm <= (quo > 16'd32767) ? 16'sh7FFF : $signed(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position   <= '0;
      y_position   <= '0;
      pressed_bits <= '0;
      hat_code     <= '0;
    end else if (ctl.commit) begin
      if (cmd_r == CMD_AXIS && idx_r == AXIS_X) begin
        x_position <= norm;
      end
      if (cmd_r == CMD_AXIS && idx_r == AXIS_Y) begin
        y_position <= norm;
      end
      if (cmd_r == CMD_BTN_DOWN || cmd_r == CMD_BTN_UP) begin
        pressed_bits <= (pressed_bits & ~bit_mask) | want;
      end
      if (cmd_r == CMD_HAT) begin
        hat_code <= val_r[3:0];
      end
    end
  end

  // output register; loaded with the post-commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data.axis_x  <= (cmd_r == CMD_AXIS && idx_r == AXIS_X) ? norm : x_position;
      out_data.axis_y  <= (cmd_r == CMD_AXIS && idx_r == AXIS_Y) ? norm : y_position;
      out_data.buttons <= (cmd_r == CMD_BTN_DOWN || cmd_r == CMD_BTN_UP)
                          ? ((pressed_bits & ~bit_mask) | want) : pressed_bits;
      out_data.hat     <= (cmd_r == CMD_HAT) ? val_r[3:0] : hat_code;
    end
  end

endmodule
`default_nettype wire
